@@ sv/assert_macros.svh @@
// Assertion macros shared by the directory RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define SHD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SHD_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/shd_pkg.sv @@
// Package for the spatial hash directory: beat types, entry layout, codes and hash primes.
`default_nettype none

package shd_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;

   localparam logic [31:0] PRIME_X = 32'd73856093;
   localparam logic [31:0] PRIME_Y = 32'd19349663;
   localparam logic [31:0] PRIME_L = 32'd83492791;

   localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [15:0] key_x;
      logic signed [15:0] key_y;
      logic [3:0]         key_level;
      logic [11:0]        block_origin_x;
      logic [11:0]        block_origin_y;
      logic [12:0]        block_side;
      logic [31:0]        logical_pages_bits;
      logic [9:0]         read_slot;
   } request_type;

   typedef struct packed {
      logic [9:0]         slot;
      logic               table_full;
      logic               entry_valid;
      logic signed [15:0] entry_x;
      logic signed [15:0] entry_y;
      logic [3:0]         entry_level;
      logic [11:0]        entry_origin_x;
      logic [11:0]        entry_origin_y;
      logic [12:0]        entry_block_size;
      logic [31:0]        entry_logical_bits;
   } response_type;

   // One directory word: occupancy flag, key and payload.
   typedef struct packed {
      logic               valid;
      logic signed [15:0] key_x;
      logic signed [15:0] key_y;
      logic [3:0]         level;
      logic [11:0]        origin_x;
      logic [11:0]        origin_y;
      logic [12:0]        block_side;
      logic [31:0]        logical_bits;
   } entry_type;

   typedef struct packed {
      logic        done;
      logic [31:0] value;
   } hash_status_type;

endpackage

`default_nettype wire

@@ sv/spatial_hash_directory_insert.sv @@
// Top level of the spatial hash sector directory (open addressing, linear probing).
// Insert: hashing (the shd_hash multiplier steps, then taking the hash), probes (a memory read
//   and a check each), then the hand-over in the finish state.
// Read: a memory read, a check, then the finish state. Unused code: the finish state only. Clear:
//   a memory sweep, then the finish state. One item at a time; output stalls hold the finish state.
// Reset (synchronous) sweeps all TABLE_DEPTH slots free, one a cycle, before req_stall drops.
`default_nettype none
`include "assert_macros.svh"

module spatial_hash_directory_insert #(
   parameter int TABLE_DEPTH = shd_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire shd_pkg::request_type  req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output shd_pkg::response_type      rsp_data,
   input  wire logic                  csr_write_enable,
   input  wire logic [3:0]            csr_write_data
);
   import shd_pkg::*;

   // Slot index width and the largest k with 2^k not above the depth.
   localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int MAX_K  = $clog2(TABLE_DEPTH + 1) - 1;
   localparam logic [4:0]        MAX_K_L   = 5'(MAX_K);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);
   localparam logic [31:0]       DEPTH_U32 = 32'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_HASH,
      S_PROBE_WAIT,
      S_PROBE_CHECK,
      S_READ_WAIT,
      S_READ_CHECK,
      S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [3:0]        size_log2_ff, size_log2_in;
   logic [SLOT_W-1:0] addr_ff, addr_in;
   logic [SLOT_W-1:0] mask_ff, mask_in;
   logic [SLOT_W-1:0] probe_n_ff, probe_n_in;
   logic              report_ff, report_in;
   logic              in_range_ff, in_range_in;
   logic [10:0]       entry_count_ff, entry_count_in;
   request_type       req_ff, req_in;
   response_type      res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   response_type      rsp_data_ff, rsp_data_in;

   logic              hash_start;
   hash_status_type   hash_status;

   logic              mem_we;
   entry_type         mem_wdata;
   entry_type         rd_data_ff;
   entry_type         mem_array [TABLE_DEPTH];

   logic [4:0]        k_eff;
   logic [31:0]       mask_wide;

   shd_hash u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (req_ff),
      .status (hash_status)
   );

   // Slots in use: 2^k, with k clipped so the table never exceeds the depth.
   assign k_eff     = ({1'b0, size_log2_ff} > MAX_K_L) ? MAX_K_L : {1'b0, size_log2_ff};
   assign mask_wide = (32'd1 << k_eff) - 32'd1;

   always_comb begin
      state_in       = state_ff;
      size_log2_in   = size_log2_ff;
      addr_in        = addr_ff;
      mask_in        = mask_ff;
      probe_n_in     = probe_n_ff;
      report_in      = report_ff;
      in_range_in    = in_range_ff;
      entry_count_in = entry_count_ff;
      req_in         = req_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      hash_start     = 1'b0;
      mem_we         = 1'b0;
      mem_wdata      = '0;

      // Register writes land whenever offered; the block is idle by contract.
      if (csr_write_enable) begin
         size_log2_in = csr_write_data;
      end

      // Drop the output beat once it has been taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_SWEEP: begin
            // Free one slot per cycle; the whole word is zeroed.
            mem_we = 1'b1;
            if (addr_ff == LAST_SLOT) begin
               addr_in        = '0;
               entry_count_in = '0;
               if (report_ff) begin
                  res_in   = '0;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               addr_in = addr_ff + SLOT_W'(1);
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               mask_in = mask_wide[SLOT_W-1:0];
               unique case (req_data.operation)
                  OP_CLEAR: begin
                     addr_in   = '0;
                     report_in = 1'b1;
                     state_in  = S_SWEEP;
                  end
                  OP_INSERT: begin
                     hash_start = 1'b1;
                     state_in   = S_HASH;
                  end
                  OP_READ: begin
                     // Slots at or beyond the depth read as free.
                     addr_in     = SLOT_W'(req_data.read_slot);
                     in_range_in = ({22'd0, req_data.read_slot} < DEPTH_U32);
                     state_in    = S_READ_WAIT;
                  end
                  default: begin
                     // Unused code: no change, all-zero result.
                     res_in   = '0;
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         S_HASH: begin
            if (hash_status.done) begin
               addr_in    = hash_status.value[SLOT_W-1:0] & mask_ff;
               probe_n_in = '0;
               state_in   = S_PROBE_WAIT;
            end
         end

         S_PROBE_WAIT: begin
            // Memory read of addr_ff is in flight.
            state_in = S_PROBE_CHECK;
         end

         S_PROBE_CHECK: begin
            if (!rd_data_ff.valid) begin
               // Free slot: claim it and store key and payload.
               mem_we                 = 1'b1;
               mem_wdata.valid        = 1'b1;
               mem_wdata.key_x        = req_ff.key_x;
               mem_wdata.key_y        = req_ff.key_y;
               mem_wdata.level        = req_ff.key_level;
               mem_wdata.origin_x     = req_ff.block_origin_x;
               mem_wdata.origin_y     = req_ff.block_origin_y;
               mem_wdata.block_side   = req_ff.block_side;
               mem_wdata.logical_bits = req_ff.logical_pages_bits;
               entry_count_in         = entry_count_ff + 11'd1;
               res_in                 = '0;
               res_in.slot            = 10'(addr_ff);
               state_in               = S_FINISH;
            end else if (probe_n_ff == mask_ff) begin
               // Every slot in use was visited and taken.
               res_in            = '0;
               res_in.table_full = 1'b1;
               state_in          = S_FINISH;
            end else begin
               // Advance with wrap inside the slots in use.
               addr_in    = (addr_ff + SLOT_W'(1)) & mask_ff;
               probe_n_in = probe_n_ff + SLOT_W'(1);
               state_in   = S_PROBE_WAIT;
            end
         end

         S_READ_WAIT: begin
            state_in = S_READ_CHECK;
         end

         S_READ_CHECK: begin
            res_in      = '0;
            res_in.slot = req_ff.read_slot;
            if (in_range_ff && rd_data_ff.valid) begin
               res_in.entry_valid        = 1'b1;
               res_in.entry_x            = rd_data_ff.key_x;
               res_in.entry_y            = rd_data_ff.key_y;
               res_in.entry_level        = rd_data_ff.level;
               res_in.entry_origin_x     = rd_data_ff.origin_x;
               res_in.entry_origin_y     = rd_data_ff.origin_y;
               res_in.entry_block_size   = rd_data_ff.block_side;
               res_in.entry_logical_bits = rd_data_ff.logical_bits;
            end
            state_in = S_FINISH;
         end

         S_FINISH: begin
            // Hold the result until the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_SWEEP;
         size_log2_ff   <= SIZE_LOG2_RESET;
         addr_ff        <= '0;
         report_ff      <= 1'b0;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         size_log2_ff   <= size_log2_in;
         addr_ff        <= addr_in;
         report_ff      <= report_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      mask_ff     <= mask_in;
      probe_n_ff  <= probe_n_in;
      in_range_ff <= in_range_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Directory memory: one address for write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[addr_ff] <= mem_wdata;
      end
      rd_data_ff <= mem_array[addr_ff];
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SHD_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH), "output beat raised outside the finish state")
   `SHD_ASSERT(a_probe_in_range, clock, reset, (state_ff == S_PROBE_CHECK) |-> ((addr_ff & ~mask_ff) == '0), "probe left the slots in use")
   `SHD_ASSERT(a_probe_bound, clock, reset, (state_ff == S_PROBE_CHECK) |-> (probe_n_ff <= mask_ff), "probe count passed the table size")
   `SHD_ASSERT_ALWAYS(a_no_overwrite, clock, (mem_we && mem_wdata.valid) |-> !rd_data_ff.valid, "insert wrote over an occupied slot")

endmodule

`default_nettype wire

@@ sv/shd_hash.sv @@
// Iterative key hash: one shared 32x32 multiplier, three products XOR-folded.
`default_nettype none

module shd_hash (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire shd_pkg::request_type    key,
   output shd_pkg::hash_status_type     status
);
   import shd_pkg::*;

   logic [1:0]  step_ff, step_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] operand;
   logic [31:0] prime;
   logic [31:0] mul_lo;

   always_comb begin
      unique case (step_ff)
         2'd0: begin
            operand = {{16{key.key_x[15]}}, key.key_x};
            prime   = PRIME_X;
         end
         2'd1: begin
            operand = {{16{key.key_y[15]}}, key.key_y};
            prime   = PRIME_Y;
         end
         2'd2: begin
            operand = {28'd0, key.key_level};
            prime   = PRIME_L;
         end
         default: begin
            operand = '0;
            prime   = '0;
         end
      endcase
   end

   // Low word of the product only: the hash works modulo 2^32.
   assign mul_lo = 32'(operand * prime);

   always_comb begin
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = 2'd0;
         acc_in  = '0;
      end else if (run_ff) begin
         if (step_ff != 2'd3) begin
            prod_in = mul_lo;
         end
         if (step_ff != 2'd0) begin
            acc_in = acc_ff ^ prod_ff;
         end
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign status.done  = done_ff;
   assign status.value = acc_ff;

endmodule

`default_nettype wire
